/* rtl/core/sse_pkg.sv */
// Shared types, constants and controller/datapath interface for the shell sort engine.
package sse_pkg;

    // Default sizing handed to the top-level parameters
    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    // Fixed width of the key fields on the ports
    localparam int KEY_W = 32;

    typedef struct packed {
        logic [KEY_W-1:0] key_in;
        logic             last_item;
    } t_in;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic             last_out;
        logic             overflow;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_GAP,
        S_PASS,
        S_RDI,
        S_TMP,
        S_CMP,
        S_PUT,
        S_EMIT0,
        S_EMIT1,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // store incoming key, or flag it as dropped
        logic gap_init;   // gap = count / 2
        logic gap_half;   // gap = gap / 2
        logic i_init;     // i = gap
        logic rd_i;       // read entry i, j = i
        logic rd_tmp;     // hold entry i, read entry j - gap
        logic shift;      // move entry j - gap up to j, step j down
        logic place;      // write held key at j, advance i
        logic emit0;      // read entry 0
        logic emit1;      // load first result, read entry 1
        logic emit_hold;  // result waits, keep reading next entry
        logic emit_next;  // result taken, load the next one
        logic done;       // final result taken, clear the batch
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic gap_zero;   // gap has reached zero
        logic i_done;     // i has passed the last key
        logic greater;    // entry j - gap sorts after the held key
        logic j_more;     // another step down stays in range
        logic emit_last;  // current result is the final key
    } t_stat;

endpackage

/* rtl/core/sse_ctrl.sv */
// Controller state machine: load, gapped insertion passes and result emission.
module sse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_item,
    input  logic          i_out_stall,
    input  sse_pkg::t_stat i_stat,
    output sse_pkg::t_cmd  o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);
    import sse_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_item) begin
                        n_state = S_GAP;
                    end
                end
            end
            S_GAP: begin
                o_cmd.gap_init = 1'b1;
                n_state        = S_PASS;
            end
            S_PASS: begin
                if (i_stat.gap_zero) begin
                    n_state = S_EMIT0;
                end else begin
                    o_cmd.i_init = 1'b1;
                    n_state      = S_RDI;
                end
            end
            S_RDI: begin
                if (i_stat.i_done) begin
                    o_cmd.gap_half = 1'b1;
                    n_state        = S_PASS;
                end else begin
                    o_cmd.rd_i = 1'b1;
                    n_state    = S_TMP;
                end
            end
            S_TMP: begin
                o_cmd.rd_tmp = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (i_stat.greater) begin
                    o_cmd.shift = 1'b1;
                    if (!i_stat.j_more) begin
                        n_state = S_PUT;
                    end
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_RDI;
                end
            end
            S_PUT: begin
                o_cmd.place = 1'b1;
                n_state     = S_RDI;
            end
            S_EMIT0: begin
                o_cmd.emit0 = 1'b1;
                n_state     = S_EMIT1;
            end
            S_EMIT1: begin
                o_cmd.emit1 = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_stall) begin
                    o_cmd.emit_hold = 1'b1;
                end else if (i_stat.emit_last) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_LOAD;
                end else begin
                    o_cmd.emit_next = 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

/* rtl/core/sse_dpath.sv */
// Datapath: key memory, index counters, key comparator and result register.
module sse_dpath #(
    parameter int MAX_KEYS = sse_pkg::MAX_KEYS_DEF,
    parameter int KEY_BITS = sse_pkg::KEY_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sse_pkg::t_cmd             i_cmd,
    input  logic [sse_pkg::KEY_W-1:0] i_key,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_data,
    output sse_pkg::t_stat            o_stat,
    output sse_pkg::t_out             o_out_data
);
    import sse_pkg::*;

    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W = $clog2(MAX_KEYS);
    localparam logic [CNT_W-1:0]    MAX_CNT   = CNT_W'(MAX_KEYS);
    localparam logic [KEY_BITS-1:0] SIGN_MASK = KEY_BITS'(1) << (KEY_BITS - 1);

    logic [KEY_BITS-1:0] r_mem [MAX_KEYS];
    logic [KEY_BITS-1:0] r_rdata;
    logic [KEY_BITS-1:0] r_tmp,     n_tmp;
    logic [KEY_BITS-1:0] r_out_key, n_out_key;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [CNT_W-1:0]    r_gap,     n_gap;
    logic [CNT_W-1:0]    r_i,       n_i;
    logic [CNT_W-1:0]    r_j,       n_j;
    logic [CNT_W-1:0]    r_k,       n_k;
    logic                r_dropped, n_dropped;
    logic                r_signed,  n_signed;

    logic [CNT_W-1:0]    j_dn;
    logic [CNT_W-1:0]    j_dn2;
    logic [CNT_W-1:0]    k_inc;
    logic [CNT_W-1:0]    k_inc2;
    logic [CNT_W-1:0]    rd_sel;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic                wr_en;
    logic [KEY_BITS-1:0] flip;
    logic                room;

    assign j_dn   = r_j - r_gap;
    assign j_dn2  = j_dn - r_gap;
    assign k_inc  = r_k + CNT_W'(1);
    assign k_inc2 = r_k + CNT_W'(2);
    assign room   = (r_count < MAX_CNT);

    // Read address select
    always_comb begin
        rd_sel = '0;
        if (i_cmd.rd_i) begin
            rd_sel = r_i;
        end else if (i_cmd.rd_tmp) begin
            rd_sel = j_dn;
        end else if (i_cmd.shift) begin
            rd_sel = j_dn2;
        end else if (i_cmd.emit0) begin
            rd_sel = '0;
        end else if (i_cmd.emit1) begin
            rd_sel = CNT_W'(1);
        end else if (i_cmd.emit_next) begin
            rd_sel = k_inc2;
        end else if (i_cmd.emit_hold) begin
            rd_sel = k_inc;
        end
    end
    assign rd_addr = rd_sel[ADDR_W-1:0];

    // Write port select
    assign wr_en   = (i_cmd.load && room) || i_cmd.shift || i_cmd.place;
    assign wr_addr = i_cmd.load ? r_count[ADDR_W-1:0] : r_j[ADDR_W-1:0];
    assign wr_data = i_cmd.load  ? KEY_BITS'(i_key) :
                     i_cmd.shift ? r_rdata : r_tmp;

    // Key memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Next values of counters and holding registers
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        n_gap     = r_gap;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_tmp     = r_tmp;
        n_out_key = r_out_key;
        n_signed  = r_signed;
        if (i_cmd.load) begin
            if (room) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_dropped = 1'b1;
            end
        end
        if (i_cmd.done) begin
            n_count   = '0;
            n_dropped = 1'b0;
        end
        if (i_cmd.gap_init) begin
            n_gap = r_count >> 1;
        end else if (i_cmd.gap_half) begin
            n_gap = r_gap >> 1;
        end
        if (i_cmd.i_init) begin
            n_i = r_gap;
        end else if (i_cmd.place) begin
            n_i = r_i + CNT_W'(1);
        end
        if (i_cmd.rd_i) begin
            n_j = r_i;
        end else if (i_cmd.shift) begin
            n_j = j_dn;
        end
        if (i_cmd.rd_tmp) begin
            n_tmp = r_rdata;
        end
        if (i_cmd.emit1) begin
            n_k = '0;
        end else if (i_cmd.emit_next) begin
            n_k = k_inc;
        end
        if (i_cmd.emit1 || i_cmd.emit_next) begin
            n_out_key = r_rdata;
        end
        if (i_cfg_valid) begin
            n_signed = i_cfg_data;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_signed  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_signed  <= n_signed;
        end
    end

    // Index and payload registers
    always_ff @(posedge i_clk) begin
        r_gap     <= n_gap;
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_tmp     <= n_tmp;
        r_out_key <= n_out_key;
    end

    // In signed mode, compare with the sign bit flipped for two's complement order
    assign flip = r_signed ? SIGN_MASK : '0;

    assign o_stat.gap_zero  = (r_gap == '0);
    assign o_stat.i_done    = (r_i >= r_count);
    assign o_stat.greater   = ((r_rdata ^ flip) > (r_tmp ^ flip));
    assign o_stat.j_more    = (j_dn >= r_gap);
    assign o_stat.emit_last = (k_inc == r_count);

    assign o_out_data.sorted_key = KEY_W'(r_out_key);
    assign o_out_data.last_out   = o_stat.emit_last;
    assign o_out_data.overflow   = r_dropped;

endmodule

/* rtl/core/shell_sort_engine_unit.sv */
// Top level of the shell sort engine: controller and datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (key_in, last_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (sorted_key,
//          |           |                           |   last_out, overflow)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (signed_compare)
//
// Keys load at one per cycle; the item marked last starts the sort.
// Each gapped insertion reads key i, holds it, then compares and moves one key
// per step; passes halve the gap until it reaches zero. All of this goes through
// the single write port and registered read of the key memory, and the sort time
// for a batch of N keys depends on N and on the data.
// Emission primes through the EMIT0 and EMIT1 states, then gives one result per cycle while not stalled.
// No key is taken while a batch sorts or emits. Reset is synchronous, active low.
module shell_sort_engine_unit #(
    parameter int MAX_KEYS = sse_pkg::MAX_KEYS_DEF,
    parameter int KEY_BITS = sse_pkg::KEY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sse_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sse_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);
    import sse_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Register writes are taken at any time
    assign o_cfg_ready = 1'b1;

    sse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_item (i_in_data.last_item),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    sse_dpath #(
        .MAX_KEYS (MAX_KEYS),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key       (i_in_data.key_in),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/core/sse_chk.sv */
// Port-level checker for the shell sort engine, bound to the top level.
module sse_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input sse_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input sse_pkg::t_out o_out_data
);

    // Hold off input while results are shown
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while results pending");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // Drop valid after the final result transfer
    a_end_of_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_out) |=> !o_out_valid)
        else $error("valid after final result");

    // Stall input once the closing key of a batch transfers
    a_sort_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.last_item) |=> o_in_stall)
        else $error("input not stalled after closing key");

endmodule

bind shell_sort_engine_unit sse_chk u_sse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
